### design/sliding_median_filter_core_macros.svh
// ----------------------------------------------------------------------------
// Sliding median filter assertion macros
// Shared property wrappers clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_FILTER_CORE_MACROS_SVH
`define SLIDING_MEDIAN_FILTER_CORE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SMF_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/smf_pkg.sv
// ----------------------------------------------------------------------------
// Sliding median filter package
// Window geometry, rank targets, sample type, sequencer states and controls.
// ----------------------------------------------------------------------------
package smf_pkg;

   localparam int WINDOW_SIZE = 5;
   localparam int SAMPLE_W    = 10;
   localparam int LAST_IDX    = WINDOW_SIZE - 1;
   localparam int IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);

   // Sorted positions of the two middle values; equal for an odd window.
   localparam int RANK_HI = WINDOW_SIZE / 2;
   localparam int RANK_LO = ((WINDOW_SIZE % 2) == 1) ? (WINDOW_SIZE / 2) : (WINDOW_SIZE / 2 - 1);

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;

   localparam sample_type RESET_LEVEL = sample_type'(512);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;        // request accepted, new sample enters the ring
      logic inner_step;  // one compare of candidate against one ring entry
      logic outer_step;  // last compare for this candidate, move to the next
      logic finish;      // both middle values are known
   } ctl_type;

endpackage

### design/smf_ring.sv
// ----------------------------------------------------------------------------
// Sliding median filter sample ring
// Holds the last WINDOW_SIZE samples and a rotating working copy. The ring
// presents the current candidate and the working copy presents the entry it
// is compared against.
// ----------------------------------------------------------------------------
module smf_ring (
   input  logic                clock,
   input  logic                reset,
   input  smf_pkg::ctl_type    ctl,
   input  smf_pkg::sample_type sample,
   output smf_pkg::sample_type cand,
   output smf_pkg::sample_type other
);
   import smf_pkg::*;

   sample_type window_ff [WINDOW_SIZE];
   sample_type window_in [WINDOW_SIZE];
   sample_type work_ff   [WINDOW_SIZE];
   sample_type work_in   [WINDOW_SIZE];
   sample_type shifted   [WINDOW_SIZE];

   // The oldest sample drops out at index zero. The median ignores order, so
   // a shift line holds the same set as a ring with a write pointer.
   always_comb begin
      for (int k = 0; k < WINDOW_SIZE; k++) begin
         if (k == LAST_IDX) begin
            shifted[k] = sample;
         end else begin
            shifted[k] = window_ff[k+1];
         end
      end
   end

   // Each full pass of rotations restores the original alignment.
   always_comb begin
      for (int k = 0; k < WINDOW_SIZE; k++) begin
         window_in[k] = window_ff[k];
         work_in[k]   = work_ff[k];
         if (ctl.load) begin
            window_in[k] = shifted[k];
            work_in[k]   = shifted[k];
         end else begin
            if (ctl.outer_step) begin
               window_in[k] = window_ff[(k + 1) % WINDOW_SIZE];
            end
            if (ctl.inner_step) begin
               work_in[k] = work_ff[(k + 1) % WINDOW_SIZE];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW_SIZE; k++) begin
            window_ff[k] <= RESET_LEVEL;
         end
      end else begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign cand  = window_ff[0];
   assign other = work_ff[0];

endmodule

### design/smf_rank.sv
// ----------------------------------------------------------------------------
// Sliding median filter rank unit
// One shared comparator counts how many entries lie below and at or below
// the candidate, and latches the candidates that land on the middle ranks.
// ----------------------------------------------------------------------------
`include "sliding_median_filter_core_macros.svh"

module smf_rank (
   input  logic                clock,
   input  logic                reset,
   input  smf_pkg::ctl_type    ctl,
   input  smf_pkg::sample_type cand,
   input  smf_pkg::sample_type other,
   output smf_pkg::sample_type median
);
   import smf_pkg::*;

   cnt_type    lt_cnt_ff, lt_cnt_in;
   cnt_type    le_cnt_ff, le_cnt_in;
   logic       found_lo_ff, found_lo_in;
   logic       found_hi_ff, found_hi_in;
   sample_type lo_val_ff, lo_val_in;
   sample_type hi_val_ff, hi_val_in;
   cnt_type    lt_next;
   cnt_type    le_next;
   logic       hit_lo;
   logic       hit_hi;
   logic [SAMPLE_W:0] mid_sum;

   assign lt_next = lt_cnt_ff + cnt_type'(other < cand);
   assign le_next = le_cnt_ff + cnt_type'(other <= cand);

   // The candidate sits at sorted position r when fewer than or exactly r
   // entries are smaller and more than r entries are smaller or equal.
   assign hit_lo = (lt_next <= cnt_type'(RANK_LO)) && (le_next > cnt_type'(RANK_LO));
   assign hit_hi = (lt_next <= cnt_type'(RANK_HI)) && (le_next > cnt_type'(RANK_HI));

   always_comb begin
      lt_cnt_in   = lt_cnt_ff;
      le_cnt_in   = le_cnt_ff;
      found_lo_in = found_lo_ff;
      found_hi_in = found_hi_ff;
      lo_val_in   = lo_val_ff;
      hi_val_in   = hi_val_ff;
      if (ctl.load) begin
         lt_cnt_in   = '0;
         le_cnt_in   = '0;
         found_lo_in = 1'b0;
         found_hi_in = 1'b0;
      end else if (ctl.outer_step) begin
         lt_cnt_in = '0;
         le_cnt_in = '0;
         if (hit_lo) begin
            found_lo_in = 1'b1;
            lo_val_in   = cand;
         end
         if (hit_hi) begin
            found_hi_in = 1'b1;
            hi_val_in   = cand;
         end
      end else if (ctl.inner_step) begin
         lt_cnt_in = lt_next;
         le_cnt_in = le_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_cnt_ff   <= '0;
         le_cnt_ff   <= '0;
         found_lo_ff <= 1'b0;
         found_hi_ff <= 1'b0;
      end else begin
         lt_cnt_ff   <= lt_cnt_in;
         le_cnt_ff   <= le_cnt_in;
         found_lo_ff <= found_lo_in;
         found_hi_ff <= found_hi_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_val_ff <= lo_val_in;
      hi_val_ff <= hi_val_in;
   end

   // For an odd window both values are the same and the mean is exact.
   assign mid_sum = {1'b0, lo_val_ff} + {1'b0, hi_val_ff};
   assign median  = mid_sum[SAMPLE_W:1];

   `SMF_ASSERT_ALWAYS(a_cnt_order, (le_cnt_ff >= lt_cnt_ff), "rank counters out of order")
   `SMF_ASSERT_ALWAYS(a_found_both, (!ctl.finish || (found_lo_ff && found_hi_ff)), "middle rank missing at finish")
   `SMF_ASSERT_ALWAYS(a_mid_order, (!ctl.finish || (lo_val_ff <= hi_val_ff)), "middle values out of order")

endmodule

### design/smf_seq.sv
// ----------------------------------------------------------------------------
// Sliding median filter sequencer
// Walks every candidate against every ring entry, then hands the median to
// the result register.
// ----------------------------------------------------------------------------
`include "sliding_median_filter_core_macros.svh"

module smf_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             out_free,
   output logic             req_ready,
   output smf_pkg::ctl_type ctl
);
   import smf_pkg::*;

   state_type state_ff, state_in;
   idx_type   outer_ff, outer_in;
   idx_type   inner_ff, inner_in;
   logic      inner_last;
   logic      outer_last;

   assign inner_last = (inner_ff == idx_type'(LAST_IDX));
   assign outer_last = (outer_ff == idx_type'(LAST_IDX));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (inner_last && outer_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      ctl            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         ST_SCAN: begin
            ctl.inner_step = 1'b1;
            ctl.outer_step = inner_last;
         end
         ST_FINISH: begin
            ctl.finish = 1'b1;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_comb begin
      outer_in = outer_ff;
      inner_in = inner_ff;
      if (ctl.load) begin
         outer_in = '0;
         inner_in = '0;
      end else if (ctl.inner_step) begin
         if (inner_last) begin
            inner_in = '0;
            outer_in = outer_last ? '0 : outer_ff + idx_type'(1);
         end else begin
            inner_in = inner_ff + idx_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         outer_ff <= '0;
         inner_ff <= '0;
      end else begin
         state_ff <= state_in;
         outer_ff <= outer_in;
         inner_ff <= inner_in;
      end
   end

   `SMF_ASSERT_ALWAYS(a_inner_range, (inner_ff <= idx_type'(LAST_IDX)), "inner index past window")
   `SMF_ASSERT_ALWAYS(a_outer_range, (outer_ff <= idx_type'(LAST_IDX)), "outer index past window")
   `SMF_ASSERT_NEXT(a_scan_end, ((state_ff == ST_SCAN) && inner_last && outer_last), (state_ff == ST_FINISH), "scan did not end in finish")

endmodule

### design/sliding_median_filter_core.sv
// ----------------------------------------------------------------------------
// Sliding median filter core
// Median of the last WINDOW_SIZE 10-bit converter samples, found by ranking
// each sample against all others with one shared comparator.
//
//   Channel   Ports                      Direction   Moves
//   request   req_valid/ready, sample    in          one raw sample
//   response  rsp_valid/ready, median    out         median of the window
//
// A request passes an accept state, then a scan that compares every
// candidate with every ring entry on the single shared comparator, then
// a finish state.
// The next request is taken the cycle after the median enters the output
// register, even while that median still waits for rsp_ready.
// A response stall holds the finish cycle until the output register frees.
// Reset fills the window with 512 at once; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_median_filter_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  smf_pkg::sample_type req_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output smf_pkg::sample_type rsp_median
);
   import smf_pkg::*;

   ctl_type    ctl;
   sample_type cand;
   sample_type other;
   sample_type median;
   logic       out_free;
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type rsp_median_ff, rsp_median_in;

   assign out_free = !rsp_valid_ff || rsp_ready;

   smf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctl       (ctl)
   );

   smf_ring u_ring (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_sample),
      .cand   (cand),
      .other  (other)
   );

   smf_rank u_rank (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .cand   (cand),
      .other  (other),
      .median (median)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_median_in = rsp_median_ff;
      if (ctl.finish && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_median_in = median;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_median_ff <= rsp_median_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule

### tb/sv/tb_sliding_median_filter_core.sv
// ----------------------------------------------------------------------------
// Sliding median filter core testbench
// Feeds converter samples through the request channel and compares every
// median on the response channel with a model of the sample ring kept here.
// A short table of hand-picked samples runs first, then shaped random
// traffic, with random idling on both sides and one long response stall.
// ----------------------------------------------------------------------------
module tb_sliding_median_filter_core;
   timeunit 1ns;
   timeprecision 1ps;

   import smf_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int CALM_ITEMS   = 150;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 60;
   localparam int N_ROWS       = 21;

   typedef enum logic [2:0] {
      SH_UNIFORM,
      SH_NOISY,
      SH_SPIKY,
      SH_EXTREME,
      SH_RAMP
   } shape_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                typed;
      logic [SAMPLE_W-1:0] median;
   } probe_row_type;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_valid  = 1'b0;
   logic       req_ready;
   sample_type req_sample = '0;
   logic       rsp_valid;
   logic       rsp_ready  = 1'b0;
   sample_type rsp_median;

   // Model of the sample ring and its write position.
   sample_type sample_ring [WINDOW_SIZE];
   int         ring_wr;

   sample_type pending_medians [$];
   int         mismatch_count = 0;
   int         medians_seen   = 0;
   bit         calm           = 1'b0;
   bit         holding        = 1'b0;
   bit         hold_done      = 1'b0;

   // Hand-picked samples: the first few rows fill the ring from its reset
   // contents, so their medians can be typed in directly.
   probe_row_type directed_rows [N_ROWS] = '{
      '{10'd0,    1'b1, 10'd512},
      '{10'd1023, 1'b1, 10'd512},
      '{10'd1023, 1'b1, 10'd512},
      '{10'd1023, 1'b1, 10'd1023},
      '{10'd1023, 1'b1, 10'd1023},
      '{10'd1023, 1'b1, 10'd1023},
      '{10'd0,    1'b0, 10'd0},
      '{10'd0,    1'b0, 10'd0},
      '{10'd0,    1'b0, 10'd0},
      '{10'd0,    1'b0, 10'd0},
      '{10'd0,    1'b1, 10'd0},
      '{10'd1,    1'b0, 10'd0},
      '{10'd1022, 1'b0, 10'd0},
      '{10'h155,  1'b0, 10'd0},
      '{10'h2AA,  1'b0, 10'd0},
      '{10'd511,  1'b0, 10'd0},
      '{10'd513,  1'b0, 10'd0},
      '{10'd512,  1'b0, 10'd0},
      '{10'd512,  1'b0, 10'd0},
      '{10'd2,    1'b0, 10'd0},
      '{10'd1021, 1'b0, 10'd0}
   };

   sliding_median_filter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_median (rsp_median)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("sliding_median_filter_core: mismatch");
      $finish;
   end

   // Writes one sample into the ring model and returns the window median.
   function automatic sample_type filter_step(input sample_type s);
      sample_type               sorted [WINDOW_SIZE];
      sample_type               key;
      logic [SAMPLE_W:0]        pair_sum;
      int                       j;
      sample_ring[ring_wr] = s;
      ring_wr = (ring_wr + 1 >= WINDOW_SIZE) ? 0 : ring_wr + 1;
      for (int i = 0; i < WINDOW_SIZE; i++) sorted[i] = sample_ring[i];
      for (int i = 1; i < WINDOW_SIZE; i++) begin
         key = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > key) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = key;
      end
      if ((WINDOW_SIZE % 2) == 1) return sorted[WINDOW_SIZE / 2];
      pair_sum = {1'b0, sorted[WINDOW_SIZE / 2 - 1]} + {1'b0, sorted[WINDOW_SIZE / 2]};
      return sample_type'(pair_sum >> 1);
   endfunction

   task automatic flag_mismatch(input string what);
      $display("[%0t] %s", $realtime, what);
      mismatch_count++;
   endtask

   // Offers one sample, waits for the request to be taken, then records the
   // expected median and possibly leaves a gap.
   task automatic send_sample(input sample_type s, input bit typed,
                              input sample_type typed_median);
      sample_type med;
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      med = filter_step(s);
      pending_medians.push_back(typed ? typed_median : med);
      if (!calm && !holding && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         medians_seen++;
         if (pending_medians.size() == 0) begin
            flag_mismatch($sformatf("median %0d with no request outstanding", rsp_median));
         end else begin
            if (rsp_median !== pending_medians[0])
               flag_mismatch($sformatf("median %0d, expected %0d",
                                       rsp_median, pending_medians[0]));
            void'(pending_medians.pop_front());
         end
      end
   end

   initial begin : response_side
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!hold_done && medians_seen >= 30) begin
            // One long stall so the core fills up and pushes back on requests.
            holding = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
            holding = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin : request_side
      shape_type  shape;
      int         seg_left;
      int         level;
      int         ramp_step;
      int         noisy;
      sample_type s;
      shape     = SH_UNIFORM;
      seg_left  = 0;
      level     = 0;
      ramp_step = 0;
      for (int i = 0; i < WINDOW_SIZE; i++) sample_ring[i] = RESET_LEVEL;
      ring_wr = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < N_ROWS; r++)
         send_sample(directed_rows[r].sample, directed_rows[r].typed,
                     directed_rows[r].median);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            shape     = shape_type'($urandom_range(0, 4));
            seg_left  = $urandom_range(5, 30);
            level     = $urandom_range(0, 1023);
            ramp_step = int'($urandom_range(0, 40)) - 20;
         end
         seg_left--;
         case (shape)
            SH_NOISY: begin
               noisy = level + int'($urandom_range(0, 16)) - 8;
               if (noisy < 0) noisy = 0;
               if (noisy > 1023) noisy = 1023;
               s = sample_type'(noisy);
            end
            SH_SPIKY: begin
               if ($urandom_range(0, 5) == 0)
                  s = ($urandom_range(0, 1) == 1) ? sample_type'(1023) : sample_type'(0);
               else
                  s = sample_type'(level);
            end
            SH_EXTREME: begin
               case ($urandom_range(0, 3))
                  0:       s = sample_type'(0);
                  1:       s = sample_type'(1);
                  2:       s = sample_type'(1022);
                  default: s = sample_type'(1023);
               endcase
            end
            SH_RAMP: begin
               level = (level + ramp_step) & 1023;
               s = sample_type'(level);
            end
            default: s = sample_type'($urandom_range(0, 1023));
         endcase
         calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
         send_sample(s, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sliding_median_filter_core: match");
      end else begin
         $display("sliding_median_filter_core: mismatch");
      end
      $finish;
   end

endmodule
